### rtl/core/xpmd_pkg.sv
// Package for the XPM stream decoder: phase and substate codes, status codes,
// event structs and the small character tables. No dependencies.
`default_nettype none
package xpmd_pkg;

  localparam int LINE_BYTES_DEF = 1024;
  localparam int PALETTE_ENTRIES = 256;
  localparam int MAX_HEIGHT = 65535;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NAME   = 3'd1,
    PH_SIZE   = 3'd2,
    PH_COLOUR = 3'd3,
    PH_PIXEL  = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    CS_QUOTE   = 3'd0,
    CS_KEY     = 3'd1,
    CS_SEEKC   = 3'd2,
    CS_SPACE   = 3'd3,
    CS_HEX     = 3'd4,
    CS_HEXSTOP = 3'd5,
    CS_NAME    = 3'd6,
    CS_DONE    = 3'd7
  } csub_t;

  // line class in the low two bits of the comment scan register
  localparam logic [1:0] LC_OPEN    = 2'd0;
  localparam logic [1:0] LC_REAL    = 2'd1;
  localparam logic [1:0] LC_COMMENT = 2'd2;
  localparam logic [1:0] LC_SLASH   = 2'd3;

  localparam logic [2:0] ST_PIXEL      = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_BAD_COLOUR = 3'd2;
  localparam logic [2:0] ST_SIZE       = 3'd3;
  localparam logic [2:0] ST_EARLY_END  = 3'd4;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_C     = 8'h63;

  localparam logic [3:0] MAGIC_LEN = 4'd9;

  typedef struct packed {
    logic        valid;
    logic        pixel;
    logic [2:0]  status;
    logic [9:0]  column;
    logic [15:0] row;
    logic        last;
  } ev_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [31:0] data;
  } pal_wr_t;

  function automatic logic [7:0] magic_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0: ch = "/";
      4'd1: ch = "*";
      4'd2: ch = " ";
      4'd3: ch = "X";
      4'd4: ch = "P";
      4'd5: ch = "M";
      4'd6: ch = " ";
      4'd7: ch = "*";
      default: ch = "/";
    endcase
    return ch;
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // names packed first character lowest
  function automatic logic [31:0] name_rgba(input logic [55:0] n);
    logic [31:0] r;
    case (n)
      56'h00_0000_656E_6F6E: r = 32'h0000_0000; // none
      56'h00_6B63_616C_62:   r = 32'h0000_00FF; // black
      56'h00_0000_0064_6572: r = 32'hFF00_00FF; // red
      56'h00_006E_6565_7267: r = 32'h00FF_00FF; // green
      56'h00_0000_6575_6C62: r = 32'h0000_FFFF; // blue
      56'h00_776F_6C6C_6579: r = 32'hFFFF_00FF; // yellow
      56'h00_0000_6E61_7963: r = 32'h00FF_FFFF; // cyan
      56'h00_0000_7961_7267: r = 32'h8080_80FF; // gray
      default:               r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/xpmd_palette.sv
// Palette store for the XPM stream decoder: 256 x 32 memory with per-entry
// valid bits so unwritten entries read as transparent black. Uses xpmd_pkg.
`default_nettype none
module xpmd_palette
  import xpmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pal_wr_t     wr,
  input  wire logic        rd_en,
  input  wire logic [7:0]  rd_addr,
  output logic      [31:0] rd_data
);

  logic [31:0] mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] valid;
  logic [31:0] rdata;
  logic        rvalid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rvalid ? rdata : 32'h0;

endmodule
`default_nettype wire

### rtl/core/xpmd_parser.sv
// Byte parser of the XPM stream decoder: header, comments, size line,
// colour lines and pixel lines. Emits one event per byte at most. Uses xpmd_pkg.
`default_nettype none
module xpmd_parser
  import xpmd_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_input,
  output ev_t             ev,
  output pal_wr_t         wr
);

  localparam int LPW  = $clog2(LINE_BYTES);
  localparam int CMPW = (LPW > 10) ? LPW : 10;
  localparam int WLIM = (LINE_BYTES - 2 < 1023) ? LINE_BYTES - 2 : 1023;

  phase_t        parse_phase, parse_phase_next;
  logic          comment_mode, comment_mode_next;
  logic [2:0]    comment_scan, comment_scan_next;
  logic [LPW-1:0] line_position, line_position_next;
  logic [3:0]    header_match_index, header_match_index_next;
  logic [15:0]   number_value, number_value_next;
  logic [1:0]    number_count, number_count_next;
  logic          digit_run, digit_run_next;
  logic [9:0]    image_width, image_width_next;
  logic [15:0]   image_height, image_height_next;
  logic [8:0]    colour_total, colour_total_next;
  logic [8:0]    colours_done, colours_done_next;
  logic [15:0]   current_row, current_row_next;
  logic [7:0]    colour_key, colour_key_next;
  csub_t         colour_substate, colour_substate_next;
  logic [23:0]   hex_accumulator, hex_accumulator_next;
  logic [2:0]    hex_digit_count, hex_digit_count_next;
  logic [55:0]   name_chars, name_chars_next;
  logic          error_latched, error_latched_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_HEADER;
      comment_mode       <= 1'b0;
      comment_scan       <= '0;
      line_position      <= '0;
      header_match_index <= '0;
      number_value       <= '0;
      number_count       <= '0;
      digit_run          <= 1'b0;
      image_width        <= '0;
      image_height       <= '0;
      colour_total       <= '0;
      colours_done       <= '0;
      current_row        <= '0;
      colour_key         <= '0;
      colour_substate    <= CS_QUOTE;
      hex_accumulator    <= '0;
      hex_digit_count    <= '0;
      name_chars         <= '0;
      error_latched      <= 1'b0;
    end else if (fire) begin
      parse_phase        <= parse_phase_next;
      comment_mode       <= comment_mode_next;
      comment_scan       <= comment_scan_next;
      line_position      <= line_position_next;
      header_match_index <= header_match_index_next;
      number_value       <= number_value_next;
      number_count       <= number_count_next;
      digit_run          <= digit_run_next;
      image_width        <= image_width_next;
      image_height       <= image_height_next;
      colour_total       <= colour_total_next;
      colours_done       <= colours_done_next;
      current_row        <= current_row_next;
      colour_key         <= colour_key_next;
      colour_substate    <= colour_substate_next;
      hex_accumulator    <= hex_accumulator_next;
      hex_digit_count    <= hex_digit_count_next;
      name_chars         <= name_chars_next;
      error_latched      <= error_latched_next;
    end
  end

  logic        run_bad;
  logic [4:0]  hv;
  logic [19:0] num_mul;
  logic [7:0]  lc;
  logic [1:0]  cls;
  logic [1:0]  flush_k;
  logic [23:0] acc_flush;
  logic [LPW-1:0] pos;
  logic [CMPW-1:0] pos_w, width_w;
  logic        do_real;
  logic        do_run_end;
  logic        last;

  always_comb begin
    run_bad = 1'b0;
    case (number_count)
      2'd0:    run_bad = (number_value == 16'd0) || (number_value > 16'(WLIM));
      2'd1:    run_bad = (number_value == 16'd0) || (32'(number_value) > MAX_HEIGHT);
      default: run_bad = (32'(number_value) > PALETTE_ENTRIES);
    endcase
  end

  assign hv      = hex_val(data_byte);
  assign num_mul = 20'(number_value) * 20'd10 + 20'(data_byte - "0");
  assign lc      = (data_byte >= "A" && data_byte <= "Z") ? data_byte + 8'd32 : data_byte;
  assign pos     = line_position;
  assign pos_w   = CMPW'(pos);
  assign width_w = CMPW'(image_width);
  // pairs still to start: each shifts the accumulator one byte
  assign flush_k = 2'((4'd6 - {1'b0, hex_digit_count}) >> 1);

  always_comb begin
    case (flush_k)
      2'd3:    acc_flush = 24'h0;
      2'd2:    acc_flush = {hex_accumulator[7:0], 16'h0};
      2'd1:    acc_flush = {hex_accumulator[15:0], 8'h0};
      default: acc_flush = hex_accumulator;
    endcase
  end

  always_comb begin
    parse_phase_next        = parse_phase;
    comment_mode_next       = comment_mode;
    comment_scan_next       = comment_scan;
    line_position_next      = line_position;
    header_match_index_next = header_match_index;
    number_value_next       = number_value;
    number_count_next       = number_count;
    digit_run_next          = digit_run;
    image_width_next        = image_width;
    image_height_next       = image_height;
    colour_total_next       = colour_total;
    colours_done_next       = colours_done;
    current_row_next        = current_row;
    colour_key_next         = colour_key;
    colour_substate_next    = colour_substate;
    hex_accumulator_next    = hex_accumulator;
    hex_digit_count_next    = hex_digit_count;
    name_chars_next         = name_chars;
    error_latched_next      = error_latched;
    ev                      = '0;
    wr                      = '0;
    wr.addr                 = colour_key;
    cls                     = comment_scan[1:0];
    do_real                 = 1'b0;
    do_run_end              = 1'b0;
    last                    = 1'b0;

    if (!error_latched && parse_phase != PH_DONE) begin
      if (end_of_input) begin
        ev.valid = 1'b1;
        ev.status = ST_EARLY_END;
        error_latched_next = 1'b1;
      end else if (data_byte == CH_LF || line_position >= LPW'(LINE_BYTES - 1)) begin
        // line end
        line_position_next = '0;
        comment_scan_next  = '0;
        if (parse_phase == PH_HEADER) begin
          if (header_match_index < MAGIC_LEN) begin
            ev.valid = 1'b1;
            ev.status = ST_BAD_HEADER;
            error_latched_next = 1'b1;
          end else begin
            parse_phase_next = PH_NAME;
          end
        end else begin
          if (cls == LC_OPEN || cls == LC_SLASH) begin
            cls = comment_mode ? LC_COMMENT : LC_REAL;
          end
          if (cls != LC_COMMENT) begin
            case (parse_phase)
              PH_NAME: begin
                parse_phase_next = PH_SIZE;
              end
              PH_SIZE: begin
                if (digit_run && run_bad) begin
                  ev.valid = 1'b1;
                  ev.status = ST_SIZE;
                  error_latched_next = 1'b1;
                  do_run_end = 1'b1;
                end else if (number_count + 2'(digit_run) < 2'd3 && number_count != 2'd3) begin
                  do_run_end = digit_run;
                  ev.valid = 1'b1;
                  ev.status = ST_BAD_HEADER;
                  error_latched_next = 1'b1;
                end else begin
                  do_run_end = digit_run;
                  colour_substate_next = CS_QUOTE;
                end
              end
              PH_COLOUR: begin
                if (colour_substate == CS_QUOTE || colour_substate == CS_KEY ||
                    colour_substate == CS_SEEKC) begin
                  ev.valid = 1'b1;
                  ev.status = ST_BAD_COLOUR;
                  error_latched_next = 1'b1;
                end else begin
                  if (colour_substate == CS_SPACE) begin
                    wr.en = 1'b1;
                    wr.data = 32'h0;
                    name_chars_next = '0;
                  end else if (colour_substate == CS_NAME) begin
                    wr.en = 1'b1;
                    wr.data = name_rgba(name_chars);
                  end else if (colour_substate == CS_HEX || colour_substate == CS_HEXSTOP) begin
                    // pad missing digits as non-hex
                    wr.en = 1'b1;
                    wr.data = {acc_flush, 8'hFF};
                    hex_accumulator_next = acc_flush;
                    hex_digit_count_next = 3'd6;
                  end
                  colours_done_next = colours_done + 9'd1;
                  colour_substate_next = CS_QUOTE;
                  parse_phase_next = (colours_done_next >= colour_total) ? PH_PIXEL : PH_COLOUR;
                end
              end
              PH_PIXEL: begin
                current_row_next = current_row + 16'd1;
                if ({1'b0, current_row} + 17'd1 >= {1'b0, image_height}) begin
                  parse_phase_next = PH_DONE;
                end
              end
              default: ;
            endcase
          end
        end
      end else begin
        line_position_next = pos + LPW'(1);
        if (parse_phase == PH_HEADER) begin
          if (header_match_index < MAGIC_LEN) begin
            if (data_byte != magic_char(header_match_index)) begin
              ev.valid = 1'b1;
              ev.status = ST_BAD_HEADER;
              error_latched_next = 1'b1;
            end else begin
              header_match_index_next = header_match_index + 4'd1;
            end
          end
        end else if (pos == '0) begin
          if (data_byte == CH_SLASH) begin
            comment_scan_next = {1'b0, LC_SLASH};
          end else if (comment_mode) begin
            if (comment_scan[2] && data_byte == CH_SLASH) comment_mode_next = 1'b0;
            comment_scan_next = {data_byte == CH_STAR, LC_COMMENT};
          end else begin
            comment_scan_next = {1'b0, LC_REAL};
            do_real = 1'b1;
          end
        end else if (comment_scan[1:0] == LC_SLASH) begin
          if (data_byte == CH_STAR) begin
            comment_scan_next = {1'b0, LC_COMMENT};
            comment_mode_next = 1'b1;
          end else if (comment_mode) begin
            if (comment_scan[2] && data_byte == CH_SLASH) comment_mode_next = 1'b0;
            comment_scan_next = {data_byte == CH_STAR, LC_COMMENT};
          end else begin
            comment_scan_next = {1'b0, LC_REAL};
            do_real = 1'b1;
          end
        end else if (comment_scan[1:0] == LC_COMMENT) begin
          if (comment_scan[2] && data_byte == CH_SLASH) comment_mode_next = 1'b0;
          comment_scan_next = {data_byte == CH_STAR, LC_COMMENT};
        end else begin
          do_real = 1'b1;
        end
      end

      if (do_real) begin
        case (parse_phase)
          PH_SIZE: begin
            if (number_count != 2'd3) begin
              if (data_byte >= "0" && data_byte <= "9") begin
                digit_run_next = 1'b1;
                number_value_next = (num_mul > 20'd65535) ? 16'hFFFF : num_mul[15:0];
              end else if (digit_run) begin
                do_run_end = 1'b1;
                if (run_bad) begin
                  ev.valid = 1'b1;
                  ev.status = ST_SIZE;
                  error_latched_next = 1'b1;
                end
              end
            end
          end
          PH_COLOUR: begin
            case (colour_substate)
              CS_QUOTE: begin
                if (data_byte == CH_QUOTE) colour_substate_next = CS_KEY;
              end
              CS_KEY: begin
                colour_key_next = data_byte;
                colour_substate_next = CS_SEEKC;
              end
              CS_SEEKC: begin
                if (data_byte == CH_C) colour_substate_next = CS_SPACE;
              end
              CS_SPACE: begin
                if (data_byte != CH_SPACE) begin
                  hex_digit_count_next = '0;
                  hex_accumulator_next = '0;
                  name_chars_next = '0;
                  if (data_byte == CH_HASH) begin
                    colour_substate_next = CS_HEX;
                  end else if (!is_alnum(data_byte)) begin
                    wr.en = 1'b1;
                    wr.data = 32'h0;
                    colour_substate_next = CS_DONE;
                  end else begin
                    name_chars_next = {48'h0, lc};
                    hex_digit_count_next = 3'd1;
                    colour_substate_next = CS_NAME;
                  end
                end
              end
              CS_HEX, CS_HEXSTOP: begin
                if (!hex_digit_count[0]) begin
                  hex_accumulator_next = {hex_accumulator[15:0], 4'h0, hv[3:0] & {4{hv[4]}}};
                  colour_substate_next = hv[4] ? CS_HEX : CS_HEXSTOP;
                end else begin
                  if (colour_substate == CS_HEX && hv[4]) begin
                    hex_accumulator_next = {hex_accumulator[23:8], hex_accumulator[3:0], hv[3:0]};
                  end
                  colour_substate_next = CS_HEX;
                end
                hex_digit_count_next = hex_digit_count + 3'd1;
                if (hex_digit_count_next >= 3'd6) begin
                  wr.en = 1'b1;
                  wr.data = {hex_accumulator_next, 8'hFF};
                  colour_substate_next = CS_DONE;
                end
              end
              CS_NAME: begin
                if (!is_alnum(data_byte)) begin
                  wr.en = 1'b1;
                  wr.data = name_rgba(name_chars);
                  colour_substate_next = CS_DONE;
                end else if (hex_digit_count < 3'd7) begin
                  name_chars_next[8*hex_digit_count +: 8] = lc;
                  hex_digit_count_next = hex_digit_count + 3'd1;
                end
              end
              default: ;
            endcase
          end
          PH_PIXEL: begin
            if (pos_w >= CMPW'(1) && pos_w <= width_w) begin
              last = ({1'b0, current_row} + 17'd1 == {1'b0, image_height}) &&
                     (pos_w == width_w);
              ev.valid  = 1'b1;
              ev.pixel  = 1'b1;
              ev.status = ST_PIXEL;
              ev.column = 10'(pos_w - CMPW'(1));
              ev.row    = current_row;
              ev.last   = last;
              if (last) parse_phase_next = PH_DONE;
            end
          end
          default: ;
        endcase
      end

      if (do_run_end) begin
        case (number_count)
          2'd0:    image_width_next  = number_value[9:0];
          2'd1:    image_height_next = number_value;
          default: colour_total_next = number_value[8:0];
        endcase
        number_count_next = number_count + 2'd1;
        number_value_next = '0;
        digit_run_next    = 1'b0;
      end

      // size line accepted: enter the colour section, or the pixels if no colours are due
      if (parse_phase == PH_SIZE && colour_substate_next == CS_QUOTE &&
          !error_latched_next && (data_byte == CH_LF ||
          line_position >= LPW'(LINE_BYTES - 1)) && cls != LC_COMMENT) begin
        parse_phase_next = (colours_done >= colour_total_next) ? PH_PIXEL : PH_COLOUR;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/xpm_image_stream_decoder.sv
// XPM image stream decoder, top level: byte parser, palette store, a result
// stage and the output register. Uses xpmd_pkg, xpmd_parser, xpmd_palette.
//
//   port group | dir | payload
//   s_axis     | in  | tdata[7:0] data_byte; tuser end_of_input
//   m_axis     | out | tdata red,green,blue,alpha,column,row; tuser status; tlast
//
// One byte is taken per cycle while the input is not stalled. A byte that yields
// a pixel reads the palette at accept; the registered read and the event wait in
// the result stage and then move to the output register. Reset (rst, sync)
// clears parser state and the palette valid bits at once; no clearing pass.
// A stalled output holds the result stage, and the input stalls only when
// both the result stage and the output register are full.
`default_nettype none
module xpm_image_stream_decoder
  import xpmd_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [41:32] column,
  // [57:42] row, [63:58] zero
  output logic      [63:0] m_axis_tdata,
  output logic      [2:0]  m_axis_tuser,   // [2:0] status
  output logic             m_axis_tlast    // last_pixel
);

  logic    in_fire;
  ev_t     ev;
  pal_wr_t wr;
  logic [31:0] rgba;

  // result stage: event waiting on its palette read
  logic    a_valid;
  ev_t     a_ev;
  logic    a_move;

  assign a_move        = a_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !a_valid || a_move;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  xpmd_parser #(
    .LINE_BYTES (LINE_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (in_fire),
    .data_byte    (s_axis_tdata),
    .end_of_input (s_axis_tuser),
    .ev           (ev),
    .wr           (wr)
  );

  // write only on accepted bytes; read the pixel entry alongside
  pal_wr_t wr_gated;
  always_comb begin
    wr_gated    = wr;
    wr_gated.en = wr.en && in_fire;
  end

  xpmd_palette u_palette (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr_gated),
    .rd_en   (in_fire && ev.pixel),
    .rd_addr (s_axis_tdata),
    .rd_data (rgba)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= ev.valid;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_ev <= ev;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (a_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      if (a_ev.pixel) begin
        m_axis_tdata <= {6'h0, a_ev.row, a_ev.column,
                         rgba[7:0], rgba[15:8], rgba[23:16], rgba[31:24]};
      end else begin
        m_axis_tdata <= '0;
      end
      m_axis_tuser <= a_ev.status;
      m_axis_tlast <= a_ev.last;
    end
  end

  // error words carry nothing but their status
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_PIXEL |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("error word with payload");

  // a waiting event holds until it moves on
  assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_move && !in_fire |=> a_valid && $stable(a_ev))
    else $error("result stage lost its event");

  // every event of an accepted byte lands in the result stage
  assert property (@(posedge clk) disable iff (rst)
    in_fire && ev.valid |=> a_valid)
    else $error("event dropped at accept");

endmodule
`default_nettype wire
